// ----- design/ssm_pkg.sv -----
// ----------------------------------------------------------------------------
// ssm_pkg: shared types and constants of the scope sample measure unit
// Item types, register codes, controller states, command and status groups,
// and the fixed constants of the measurement arithmetic.
// ----------------------------------------------------------------------------
package ssm_pkg;

    // Field widths
    localparam int SAMPLE_W      = 12;
    localparam int BYTE_W        = 8;
    localparam int CAP_INDEX_W   = 10;
    localparam int FREQ_W        = 8;
    localparam int VOLT_INT_W    = 6;
    localparam int VOLT_FRAC_W   = 4;
    localparam int DIVIDE_W      = 8;
    localparam int GAIN_W        = 4;
    localparam int TICK_W        = 7;
    localparam int RUN_W         = 16;
    localparam int QUIET_W       = 10;

    // Configuration port
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 8;

    // Ring depth default
    localparam int CAPTURE_DEPTH_DEFAULT = 1024;

    // Frequency quotient: dividend and divisor widths
    localparam int FREQ_NUM_W    = 13;
    localparam int PROD_W        = 23;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_DIVIDE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN          = 1'd1;

    // Register reset values
    localparam logic [DIVIDE_W-1:0] DIVIDE_RESET = 8'd128;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 4'd1;

    // Measurement constants
    localparam logic [DIVIDE_W-1:0]   DIVIDE_MAX      = 8'd128;
    localparam logic [SAMPLE_W-1:0]   MID_SCALE       = 12'd2048;
    localparam logic [RUN_W-1:0]      RUN_MAX         = 16'hFFFF;
    localparam logic [FREQ_NUM_W-1:0] FREQ_NUMERATOR  = 13'd5000;
    localparam logic [19:0]           FLUSH_NUMERATOR = 20'd1000;
    localparam logic [FREQ_W-1:0]     FREQ_SAT        = 8'd255;
    localparam logic [8:0]            MOD_BASE        = 9'd255;

    // Reciprocals for division by constants
    // x / 2550 = (x * VOLT_INT_RECIP) >> 28, exact for x below 2^17
    localparam logic [16:0] VOLT_INT_RECIP = 17'd105269;
    // x / 10 = (x * TENTH_RECIP) >> 19, exact for x below 2^14
    localparam logic [15:0] TENTH_RECIP    = 16'd52429;
    // x / 26 = (x * DIGIT_RECIP) >> 16, exact for x below 255
    localparam logic [11:0] DIGIT_RECIP    = 12'd2521;

    // Input and result items
    typedef struct packed {
        logic [SAMPLE_W-1:0] adc_sample;
    } t_in_item;

    typedef struct packed {
        logic                   sample_taken;
        logic [CAP_INDEX_W-1:0] capture_index;
        logic [BYTE_W-1:0]      capture_byte;
        logic [FREQ_W-1:0]      frequency_hz;
        logic [BYTE_W-1:0]      peak_level;
        logic [VOLT_INT_W-1:0]  volts_whole;
        logic [VOLT_FRAC_W-1:0] volts_tenth;
    } t_out_item;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_BRANCH,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_VOLT_MUL,
        ST_VOLT_GAIN,
        ST_VOLT_MOD,
        ST_VOLT_FRAC,
        ST_DONE
    } t_ssm_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic eval;
        logic div_start;
        logic freq_write;
        logic volt_mul;
        logic volt_gain;
        logic volt_mod;
        logic volt_frac;
        logic out_load;
    } t_ssm_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic freq_req;
        logic peak_req;
        logic div_busy;
        logic out_free;
    } t_ssm_stat;

endpackage

// ----- design/ssm_in_if.sv -----
// ----------------------------------------------------------------------------
// ssm_in_if: sample input channel
// Valid/ready channel carrying one converter sample per transfer.
// ----------------------------------------------------------------------------
interface ssm_in_if;
    import ssm_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/ssm_out_if.sv -----
// ----------------------------------------------------------------------------
// ssm_out_if: measurement result channel
// Valid/ready channel carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface ssm_out_if;
    import ssm_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/ssm_divider.sv -----
// ----------------------------------------------------------------------------
// ssm_divider: restoring divider for the frequency quotient
// Divides the fixed numerator by the run product, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ssm_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ssm_pkg::PROD_W-1:0]     i_divisor,
    output logic                           o_busy,
    output logic [ssm_pkg::FREQ_NUM_W-1:0] o_quotient
);
    import ssm_pkg::*;

    localparam int CntW = $clog2(FREQ_NUM_W);
    localparam logic [CntW-1:0] CntLast = CntW'(FREQ_NUM_W - 1);

    logic                  r_busy;
    logic [CntW-1:0]       r_count;
    logic [FREQ_NUM_W-1:0] r_rem;
    logic [FREQ_NUM_W-1:0] r_quot;
    logic [PROD_W-1:0]     r_divisor;

    logic [FREQ_NUM_W:0]   rem_shift;
    logic                  fits;
    logic [PROD_W-1:0]     rem_diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_shift = {r_rem, r_quot[FREQ_NUM_W-1]};
        fits      = {{(PROD_W-FREQ_NUM_W-1){1'b0}}, rem_shift} >= r_divisor;
        rem_diff  = {{(PROD_W-FREQ_NUM_W-1){1'b0}}, rem_shift} - r_divisor;
    end

    // Control: busy flag and step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_count <= '0;
        end else if (r_busy) begin
            r_count <= r_count + 1'b1;
            if (r_count == CntLast) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quot    <= FREQ_NUMERATOR;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= rem_diff[FREQ_NUM_W-1:0];
            end else begin
                r_rem <= rem_shift[FREQ_NUM_W-1:0];
            end
            r_quot <= {r_quot[FREQ_NUM_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quot;
endmodule

// ----- design/ssm_datapath.sv -----
// ----------------------------------------------------------------------------
// ssm_datapath: measurement datapath
// Holds the registers, tick and ring counters, run and quiet counters, the
// peak and volts arithmetic, the frequency divider and the result register.
// ----------------------------------------------------------------------------
module ssm_datapath #(
    parameter int CAPTURE_DEPTH = ssm_pkg::CAPTURE_DEPTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ssm_pkg::t_ssm_cmd               i_cmd,
    output ssm_pkg::t_ssm_stat              o_stat,
    input  ssm_pkg::t_in_item               i_in_payload,
    input  logic                            i_cfg_we,
    input  logic [ssm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ssm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output ssm_pkg::t_out_item              o_out_payload
);
    import ssm_pkg::*;

    localparam int PtrW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
    localparam int IdxW = (PtrW < CAP_INDEX_W) ? PtrW : CAP_INDEX_W;
    localparam logic [PtrW-1:0] PtrLast = PtrW'(CAPTURE_DEPTH - 1);

    // Configuration
    logic [DIVIDE_W-1:0]    r_divide;
    logic [GAIN_W-1:0]      r_gain;

    // Measurement state
    logic [SAMPLE_W-1:0]    r_sample;
    logic [TICK_W-1:0]      r_tick;
    logic [PtrW-1:0]        r_ptr;
    logic [RUN_W-1:0]       r_run;
    logic [FREQ_W-1:0]      r_freq;
    logic [BYTE_W-1:0]      r_peak;
    logic [VOLT_INT_W-1:0]  r_vint;
    logic [VOLT_FRAC_W-1:0] r_vfrac;
    logic [QUIET_W-1:0]     r_quiet;
    logic                   r_freq_req;
    logic                   r_peak_req;

    // Intermediate products
    logic [PROD_W-1:0]      r_prod;
    logic [13:0]            r_p33;
    logic [16:0]            r_x;
    logic [9:0]             r_p10;
    logic [13:0]            r_t;
    logic [BYTE_W-1:0]      r_rmod;

    // Capture fields and result register
    logic                   r_cap_taken;
    logic [CAP_INDEX_W-1:0] r_cap_index;
    logic [BYTE_W-1:0]      r_cap_byte;
    logic                   r_out_valid;
    t_out_item              r_out;

    // Evaluation signals
    logic [DIVIDE_W-1:0]    eff_div;
    logic [DIVIDE_W-1:0]    tick_inc;
    logic                   keep;
    logic [BYTE_W-1:0]      byte_val;
    logic                   is_high;
    logic [23:0]            run_prod;
    logic [QUIET_W:0]       quiet_inc;
    logic [QUIET_W+1:0]     quiet_plus2;
    logic [19:0]            flush_prod;
    logic                   flush_hit;
    logic                   new_peak;
    logic                   flush_now;
    logic [13:0]            p33;
    logic [16:0]            x_val;
    logic [PtrW-1:0]        ptr_next;

    // Volts and frequency arithmetic
    logic [33:0]            vint_prod;
    logic [29:0]            p10_prod;
    logic [13:0]            t_prod;
    logic [8:0]             mod_sum;
    logic [8:0]             mod_val;
    logic [19:0]            frac_prod;
    logic                   div_busy;
    logic [FREQ_NUM_W-1:0]  quotient;
    logic [FREQ_W-1:0]      freq_sat;

    // Clamp the divide setting into its working range
    always_comb begin
        if (r_divide == '0) begin
            eff_div = 8'd1;
        end else if (r_divide > DIVIDE_MAX) begin
            eff_div = DIVIDE_MAX;
        end else begin
            eff_div = r_divide;
        end
    end

    // Decide keep, run, peak and flush for the held sample
    always_comb begin
        tick_inc    = {1'b0, r_tick} + 8'd1;
        keep        = tick_inc >= eff_div;
        byte_val    = r_sample[SAMPLE_W-1:SAMPLE_W-BYTE_W];
        is_high     = r_sample >= MID_SCALE;
        run_prod    = {16'b0, eff_div} * {8'b0, r_run};
        quiet_inc   = {1'b0, r_quiet} + 11'd1;
        quiet_plus2 = {1'b0, quiet_inc} + 12'd1;
        flush_prod  = {8'b0, quiet_plus2} * {12'b0, eff_div};
        flush_hit   = flush_prod > FLUSH_NUMERATOR;
        new_peak    = keep && (byte_val > r_peak);
        flush_now   = keep && !new_peak && flush_hit;
        p33         = ({6'b0, byte_val} << 5) + {6'b0, byte_val};
        x_val       = {3'b0, p33} * {13'b0, r_gain};
        ptr_next    = (r_ptr == PtrLast) ? '0 : r_ptr + 1'b1;
    end

    // Volts steps and frequency saturation
    always_comb begin
        vint_prod = {17'b0, r_x} * {17'b0, VOLT_INT_RECIP};
        p10_prod  = {16'b0, r_p33} * {14'b0, TENTH_RECIP};
        t_prod    = {4'b0, r_p10} * {10'b0, r_gain};
        mod_sum   = {3'b0, r_t[13:8]} + {1'b0, r_t[7:0]};
        mod_val   = (mod_sum >= MOD_BASE) ? mod_sum - MOD_BASE : mod_sum;
        frac_prod = {12'b0, r_rmod} * {8'b0, DIGIT_RECIP};
        freq_sat  = (quotient > {5'b0, FREQ_SAT}) ? FREQ_SAT : quotient[FREQ_W-1:0];
    end

    // Frequency divider
    ssm_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_divisor  (r_prod),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    // Control state: registers, counters, measurements, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divide    <= DIVIDE_RESET;
            r_gain      <= GAIN_RESET;
            r_tick      <= '0;
            r_ptr       <= '0;
            r_run       <= '0;
            r_freq      <= '0;
            r_peak      <= '0;
            r_vint      <= '0;
            r_vfrac     <= '0;
            r_quiet     <= '0;
            r_freq_req  <= 1'b0;
            r_peak_req  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SAMPLE_DIVIDE: r_divide <= i_cfg_data;
                    CFG_GAIN:          r_gain   <= i_cfg_data[GAIN_W-1:0];
                    default:           r_divide <= r_divide;
                endcase
            end

            // Evaluate the held sample
            if (i_cmd.eval) begin
                r_peak_req <= new_peak;
                r_freq_req <= keep && !is_high && (r_run != '0) && !flush_now;
                if (keep) begin
                    r_tick <= '0;
                    r_ptr  <= ptr_next;
                    if (is_high) begin
                        if (r_run != RUN_MAX) begin
                            r_run <= r_run + 1'b1;
                        end
                    end else begin
                        r_run <= '0;
                    end
                    if (new_peak) begin
                        r_peak <= byte_val;
                    end else if (flush_hit) begin
                        r_peak  <= '0;
                        r_freq  <= '0;
                        r_quiet <= '0;
                    end else begin
                        r_quiet <= quiet_inc[QUIET_W-1:0];
                    end
                end else begin
                    r_tick <= tick_inc[TICK_W-1:0];
                end
            end

            // Commit computed readings
            if (i_cmd.freq_write) begin
                r_freq <= freq_sat;
            end
            if (i_cmd.volt_mul) begin
                r_vint <= vint_prod[33:28];
            end
            if (i_cmd.volt_frac) begin
                r_vfrac <= frac_prod[19:16];
            end

            // Result valid: set on load, drop on transfer
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_in_payload.adc_sample;
        end
        if (i_cmd.eval) begin
            r_prod      <= run_prod[PROD_W-1:0];
            r_p33       <= p33;
            r_x         <= x_val;
            r_cap_taken <= keep;
            r_cap_index <= keep ? CAP_INDEX_W'(r_ptr[IdxW-1:0]) : '0;
            r_cap_byte  <= keep ? byte_val : '0;
        end
        if (i_cmd.volt_mul) begin
            r_p10 <= p10_prod[28:19];
        end
        if (i_cmd.volt_gain) begin
            r_t <= t_prod;
        end
        if (i_cmd.volt_mod) begin
            r_rmod <= mod_val[BYTE_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out.sample_taken  <= r_cap_taken;
            r_out.capture_index <= r_cap_index;
            r_out.capture_byte  <= r_cap_byte;
            r_out.frequency_hz  <= r_freq;
            r_out.peak_level    <= r_peak;
            r_out.volts_whole   <= r_vint;
            r_out.volts_tenth   <= r_vfrac;
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.freq_req = r_freq_req;
        o_stat.peak_req = r_peak_req;
        o_stat.div_busy = div_busy;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_payload = r_out;
endmodule

// ----- design/ssm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssm_ctrl: sequencing controller
// Takes one sample at a time and steps the datapath through evaluation,
// the frequency division, the volts steps and the result hand-off.
// ----------------------------------------------------------------------------
module ssm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ssm_pkg::t_ssm_stat i_stat,
    output ssm_pkg::t_ssm_cmd  o_cmd
);
    import ssm_pkg::*;

    t_ssm_state r_state;
    t_ssm_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = ST_BRANCH;
            end
            ST_BRANCH: begin
                if (i_stat.freq_req) begin
                    n_state = ST_DIV_START;
                end else if (i_stat.peak_req) begin
                    n_state = ST_VOLT_MUL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.freq_write = 1'b1;
                    n_state = i_stat.peak_req ? ST_VOLT_MUL : ST_DONE;
                end
            end
            ST_VOLT_MUL: begin
                o_cmd.volt_mul = 1'b1;
                n_state        = ST_VOLT_GAIN;
            end
            ST_VOLT_GAIN: begin
                o_cmd.volt_gain = 1'b1;
                n_state         = ST_VOLT_MOD;
            end
            ST_VOLT_MOD: begin
                o_cmd.volt_mod = 1'b1;
                n_state        = ST_VOLT_FRAC;
            end
            ST_VOLT_FRAC: begin
                o_cmd.volt_frac = 1'b1;
                n_state         = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the result register is free
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

// ----- design/scope_sample_measure_unit.sv -----
// ----------------------------------------------------------------------------
// scope_sample_measure_unit: sampling front end of a small oscilloscope
// Each sample transfer is followed by evaluation, the 13-step frequency
//   divider when a kept sample ends a high run, the four volts steps on a
//   new peak, and the result load. The input takes no new sample until that
//   result loads, and the load waits for a free result register.
// Reset: synchronous, active low; registers return to divide 128 and gain 1,
//   counters and readings clear, and the result register empties.
// ----------------------------------------------------------------------------
module scope_sample_measure_unit #(
    parameter int CAPTURE_DEPTH = ssm_pkg::CAPTURE_DEPTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ssm_in_if.sink                          i_in,
    ssm_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [ssm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ssm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ssm_pkg::*;

    t_ssm_cmd  cmd;
    t_ssm_stat stat;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_payload;

    // Sequencer
    ssm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Measurement datapath
    ssm_datapath #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_in_payload  (i_in.payload),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (out_valid),
        .o_out_payload (out_payload)
    );

    assign i_in.ready    = in_ready;
    assign o_out.valid   = out_valid;
    assign o_out.payload = out_payload;
endmodule

// ----- design/ssm_checker.sv -----
// ----------------------------------------------------------------------------
// ssm_checker: port-level checks for the scope sample measure unit
// Watches the handshake ports for reset, one-at-a-time intake and result
// hand-off; bound to the top level below.
// ----------------------------------------------------------------------------
module ssm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input ssm_pkg::t_out_item i_out_payload
);
    import ssm_pkg::*;

    // Reset empties the result register and opens the input
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("result valid or input closed after reset");

    // One sample in work at a time: input closes after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input still open after a sample transfer");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_payload)))
        else $error("stalled result changed or dropped");

    // A new result appears only while a sample is in work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared while the block was idle");
endmodule

bind scope_sample_measure_unit ssm_checker u_ssm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);
